// ===== src/sgr_pkg.sv =====
// Package with the shared constants, codes and command/status types of the SGR stripper.
`timescale 1ns / 1ps
`default_nettype none

package sgr_pkg;

    // Depth of the buffer that holds the bytes of a candidate sequence.
    localparam int HOLD_DEPTH = 16;
    localparam int CNT_W      = $clog2(HOLD_DEPTH + 1);
    localparam int IDX_W      = $clog2(HOLD_DEPTH);

    // Character codes that make up an SGR sequence.
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_LBR   = 8'h5B;
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_DIG_0 = 8'h30;
    localparam logic [7:0] CH_DIG_9 = 8'h39;

    localparam logic [15:0] KEPT_MAX = 16'hFFFF;

    // Scan phase codes.
    typedef logic [1:0] phase_t;
    localparam phase_t PH_IDLE  = 2'd0;
    localparam phase_t PH_ESC   = 2'd1;
    localparam phase_t PH_PARAM = 2'd2;

    // Controller states.
    typedef enum logic [1:0] {
        S_RUN   = 2'b01,
        S_FLUSH = 2'b10
    } sgr_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic   take;
        logic   out_load;
        logic   out_from_held;
        logic   out_byte_valid;
        logic   out_end;
        logic   count_inc;
        logic   kept_clear;
        logic   hold_start;
        logic   hold_wr;
        logic   held_clear;
        logic   phase_load;
        phase_t phase_val;
        logic   rd_clr;
        logic   rd_inc;
    } sgr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        phase_t phase;
        logic   is_esc;
        logic   is_lbr;
        logic   is_m;
        logic   is_param;
        logic   held_full;
        logic   held_zero;
        logic   rd_last;
        logic   cur_last;
        logic   slot_free;
    } sgr_stat_t;

endpackage

`default_nettype wire

// ===== src/sgr_if.sv =====
// Stream interfaces for the input bytes and the result items.
`timescale 1ns / 1ps
`default_nettype none

interface sgr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last;

    modport source (output valid, output in_byte, output last, input ready);
    modport sink (input valid, input in_byte, input last, output ready);
endinterface

interface sgr_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        end_of_run;
    logic [15:0] visible_len;

    modport source (output valid, output out_byte, output byte_valid, output end_of_run,
                    output visible_len, input ready);
    modport sink (input valid, input out_byte, input byte_valid, input end_of_run,
                  input visible_len, output ready);
endinterface

`default_nettype wire

// ===== src/sgr_datapath.sv =====
// Datapath of the SGR stripper: pending byte, hold buffer, counters and output register.
`timescale 1ns / 1ps
`default_nettype none

module sgr_datapath
    import sgr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] in_byte,
    input  wire logic       last,
    input  wire sgr_cmd_t   cmd,
    output sgr_stat_t       stat,
    sgr_out_if.source       sgr_out
);

    logic [7:0]       cur_byte_reg;
    logic             cur_last_reg;
    logic [7:0]       held_mem [HOLD_DEPTH];
    logic [CNT_W-1:0] held_count_reg, held_count_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    phase_t           phase_reg, phase_next;
    logic [15:0]      kept_reg, kept_next, kept_inc;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg;
    logic             byte_valid_reg;
    logic             end_reg;
    logic [15:0]      vlen_reg;
    logic             slot_free;

    // Pending byte and buffer contents carry no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            cur_byte_reg <= in_byte;
            cur_last_reg <= last;
        end
        if (cmd.hold_start)
        begin
            held_mem[0] <= cur_byte_reg;
        end
        else if (cmd.hold_wr)
        begin
            held_mem[held_count_reg[IDX_W-1:0]] <= cur_byte_reg;
        end
        if (cmd.out_load)
        begin
            if (cmd.out_from_held)
                out_byte_reg <= held_mem[rd_idx_reg];
            else if (cmd.out_byte_valid)
                out_byte_reg <= cur_byte_reg;
            else
                out_byte_reg <= '0;
            byte_valid_reg <= cmd.out_byte_valid;
            end_reg        <= cmd.out_end;
            vlen_reg       <= cmd.count_inc ? kept_inc : kept_reg;
        end
    end

    // Byte classes of the pending byte, with the phase and buffer status for the controller.
    always_comb
    begin
        stat.phase     = phase_reg;
        stat.is_esc    = (cur_byte_reg == CH_ESC);
        stat.is_lbr    = (cur_byte_reg == CH_LBR);
        stat.is_m      = (cur_byte_reg == CH_M);
        stat.is_param  = ((cur_byte_reg >= CH_DIG_0) && (cur_byte_reg <= CH_DIG_9))
                         || (cur_byte_reg == CH_SEMI);
        stat.held_full = (held_count_reg == CNT_W'(HOLD_DEPTH));
        stat.held_zero = (held_count_reg == '0);
        stat.rd_last   = ((CNT_W'(rd_idx_reg) + CNT_W'(1)) == held_count_reg);
        stat.cur_last  = cur_last_reg;
        stat.slot_free = slot_free;
    end

    // Next values of the counters and the phase.
    always_comb
    begin
        kept_inc = (kept_reg == KEPT_MAX) ? kept_reg : kept_reg + 16'd1;

        if (cmd.kept_clear)
            kept_next = '0;
        else if (cmd.count_inc)
            kept_next = kept_inc;
        else
            kept_next = kept_reg;

        if (cmd.held_clear)
            held_count_next = '0;
        else if (cmd.hold_start)
            held_count_next = CNT_W'(1);
        else if (cmd.hold_wr)
            held_count_next = held_count_reg + CNT_W'(1);
        else
            held_count_next = held_count_reg;

        if (cmd.rd_clr)
            rd_idx_next = '0;
        else if (cmd.rd_inc)
            rd_idx_next = rd_idx_reg + IDX_W'(1);
        else
            rd_idx_next = rd_idx_reg;

        phase_next = cmd.phase_load ? cmd.phase_val : phase_reg;
    end

    // Output register: a new result may load when the slot is empty or being drained.
    always_comb
    begin
        slot_free = !out_valid_reg || sgr_out.ready;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (sgr_out.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count_reg <= '0;
            rd_idx_reg     <= '0;
            phase_reg      <= PH_IDLE;
            kept_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            held_count_reg <= held_count_next;
            rd_idx_reg     <= rd_idx_next;
            phase_reg      <= phase_next;
            kept_reg       <= kept_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign sgr_out.valid       = out_valid_reg;
    assign sgr_out.out_byte    = out_byte_reg;
    assign sgr_out.byte_valid  = byte_valid_reg;
    assign sgr_out.end_of_run  = end_reg;
    assign sgr_out.visible_len = vlen_reg;

`ifndef ASSERT_OFF
    // The hold buffer never counts past its depth.
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_count_reg <= CNT_W'(HOLD_DEPTH))
        else $error("hold count exceeds buffer depth");

    // Right after an ESC the buffer holds exactly that one byte.
    a_esc_one: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_ESC) |-> (held_count_reg == CNT_W'(1)))
        else $error("ESC phase with wrong hold count");

    // An end-only result never changes the visible count.
    a_end_only: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && !cmd.out_byte_valid) |-> (cmd.out_end && !cmd.count_inc))
        else $error("end-only result malformed");
`endif

endmodule

`default_nettype wire

// ===== src/sgr_ctrl.sv =====
// Controller of the SGR stripper: sequences absorption, emission and literal flushes.
`timescale 1ns / 1ps
`default_nettype none

module sgr_ctrl
    import sgr_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire sgr_stat_t stat,
    output sgr_cmd_t       cmd
);

    sgr_state_t state_reg, state_next;
    logic       pend_reg, pend_next;
    logic       tail_reg, tail_next;
    logic       done;
    logic       phase_idle;
    logic       brk;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        pend_next  = pend_reg;
        tail_next  = tail_reg;
        in_ready   = 1'b0;
        done       = 1'b0;
        phase_idle = (stat.phase != PH_ESC) && (stat.phase != PH_PARAM);
        // The pending byte breaks a candidate sequence.
        brk = ((stat.phase == PH_ESC) && !stat.is_lbr)
              || ((stat.phase == PH_PARAM) && !(stat.is_param && !stat.held_full)
                  && !stat.is_m);

        case (state_reg)
            S_RUN:
            begin
                if (pend_reg)
                begin
                    if (brk)
                    begin
                        // Flush held bytes literally, then reprocess the byte from idle.
                        state_next = S_FLUSH;
                        tail_next  = 1'b0;
                        cmd.rd_clr = 1'b1;
                    end
                    else if (phase_idle && !stat.is_esc)
                    begin
                        // Plain text byte passes straight to the output register.
                        if (stat.slot_free)
                        begin
                            cmd.out_load       = 1'b1;
                            cmd.out_byte_valid = 1'b1;
                            cmd.out_end        = stat.cur_last;
                            cmd.count_inc      = 1'b1;
                            cmd.kept_clear     = stat.cur_last;
                            done               = 1'b1;
                        end
                    end
                    else
                    begin
                        // Byte belongs to a candidate sequence: hold it or drop the sequence.
                        cmd.phase_load = 1'b1;
                        if (phase_idle)
                        begin
                            cmd.hold_start = 1'b1;
                            cmd.phase_val  = PH_ESC;
                        end
                        else if (stat.phase == PH_ESC)
                        begin
                            cmd.hold_wr   = 1'b1;
                            cmd.phase_val = PH_PARAM;
                        end
                        else if (stat.is_param)
                        begin
                            cmd.hold_wr   = 1'b1;
                            cmd.phase_val = PH_PARAM;
                        end
                        else
                        begin
                            cmd.held_clear = 1'b1;
                            cmd.phase_val  = PH_IDLE;
                        end
                        if (stat.cur_last)
                        begin
                            state_next = S_FLUSH;
                            tail_next  = 1'b1;
                            cmd.rd_clr = 1'b1;
                        end
                        else
                        begin
                            done = 1'b1;
                        end
                    end
                end
                in_ready = !pend_reg || done;
                if (done)
                    pend_next = 1'b0;
                if (in_valid && in_ready)
                begin
                    cmd.take  = 1'b1;
                    pend_next = 1'b1;
                end
            end

            S_FLUSH:
            begin
                if (stat.slot_free)
                begin
                    cmd.out_load = 1'b1;
                    if (stat.held_zero)
                    begin
                        // End of string with nothing to show: end-only result.
                        cmd.out_end    = 1'b1;
                        cmd.kept_clear = 1'b1;
                        cmd.phase_load = 1'b1;
                        cmd.phase_val  = PH_IDLE;
                        state_next     = S_RUN;
                        pend_next      = 1'b0;
                    end
                    else
                    begin
                        cmd.out_from_held  = 1'b1;
                        cmd.out_byte_valid = 1'b1;
                        cmd.count_inc      = 1'b1;
                        cmd.out_end        = tail_reg && stat.rd_last;
                        cmd.rd_inc         = 1'b1;
                        if (stat.rd_last)
                        begin
                            cmd.held_clear = 1'b1;
                            cmd.phase_load = 1'b1;
                            cmd.phase_val  = PH_IDLE;
                            state_next     = S_RUN;
                            if (tail_reg)
                            begin
                                cmd.kept_clear = 1'b1;
                                pend_next      = 1'b0;
                            end
                        end
                    end
                end
            end

            default:
            begin
                state_next = S_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_RUN;
            pend_reg  <= 1'b0;
            tail_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            tail_reg  <= tail_next;
        end
    end

`ifndef ASSERT_OFF
    // No new byte is taken while held bytes are being flushed.
    a_flush_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FLUSH) |-> !in_ready)
        else $error("input accepted during flush");

    // A flush always works on behalf of a pending byte.
    a_flush_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FLUSH) |-> pend_reg)
        else $error("flush without pending byte");

    // A result is loaded only into a free output slot.
    a_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> stat.slot_free)
        else $error("output register overwritten");
`endif

endmodule

`default_nettype wire

// ===== src/ansi_sgr_strip_unit.sv =====
// Top level of the SGR stripper: controller and datapath joined by command and status.
//
//  Channel  Role  Payload                                          Transfer
//  sgr_in   sink  in_byte[8], last[1]                              valid & ready
//  sgr_out  src   out_byte[8], byte_valid, end_of_run, visible_len valid & ready
//
// Plain text bytes and absorbed sequence bytes stream at one per cycle while the
// output register drains. A broken or overflowing sequence sends the controller to
// its flush state, which emits the held bytes one by one through the single read
// port of the hold buffer and then hands the breaking byte back to be scanned from
// idle. A last byte that leaves bytes held has them flushed the same way, or gives
// an end-only result when nothing is left to show. Reset clears phase and counters
// at once; there is no clearing pass. A stalled output holds the controller in place.
`timescale 1ns / 1ps
`default_nettype none

module ansi_sgr_strip_unit
    import sgr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    sgr_in_if.sink    sgr_in,
    sgr_out_if.source sgr_out
);

    sgr_cmd_t  cmd;
    sgr_stat_t stat;
    logic      in_ready;

    assign sgr_in.ready = in_ready;

    // Sequencing of each transaction.
    sgr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sgr_in.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Storage and result formation.
    sgr_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_byte (sgr_in.in_byte),
        .last    (sgr_in.last),
        .cmd     (cmd),
        .stat    (stat),
        .sgr_out (sgr_out)
    );

endmodule

`default_nettype wire

// ===== tb/ansi_sgr_strip_unit_tb.sv =====
// Self-checking testbench for the SGR sequence stripper: directed strings, random strings, idling phases.
`timescale 1ns / 1ps

module ansi_sgr_strip_unit_tb;
    import sgr_pkg::*;

    localparam int STALL_LIMIT      = 2000;
    localparam int RANDOM_PER_PHASE = 58;
    localparam int TAIL_CYCLES      = 16;
    localparam int N_PHASES         = 4;

    // One result transaction of the output channel.
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        end_of_run;
        logic [15:0] visible_len;
    } text_result_t;

    // Tracks the stripper state and the results still owed by the block.
    class sgr_strip_scoreboard;
        phase_t         scan;
        logic [7:0]     held_buf [HOLD_DEPTH];
        int             held_cnt;
        logic [15:0]    kept;
        text_result_t   pending [$];
        int             errors;

        function new();
            scan     = PH_IDLE;
            held_cnt = 0;
            kept     = '0;
            errors   = 0;
        endfunction

        // Emit a kept byte and bump the visible count, saturating at the top.
        function void emit_kept(logic [7:0] b, ref text_result_t fresh [$]);
            text_result_t r;
            if (kept != KEPT_MAX)
                kept++;
            r.out_byte    = b;
            r.byte_valid  = 1'b1;
            r.end_of_run  = 1'b0;
            r.visible_len = kept;
            fresh.push_back(r);
        endfunction

        // Send the held bytes out literally and go back to idle.
        function void release_held(ref text_result_t fresh [$]);
            for (int i = 0; i < held_cnt; i++)
                emit_kept(held_buf[i], fresh);
            held_cnt = 0;
            scan     = PH_IDLE;
        endfunction

        function void hold_byte(logic [7:0] b);
            if (held_cnt < HOLD_DEPTH) begin
                held_buf[held_cnt] = b;
                held_cnt++;
            end
        endfunction

        // Run one byte through the scanner; a breaking byte is scanned again from idle.
        function void strip_byte(logic [7:0] b, ref text_result_t fresh [$]);
            bit done;
            bit is_param;
            done     = 1'b0;
            is_param = (b >= CH_DIG_0 && b <= CH_DIG_9) || b == CH_SEMI;
            while (!done) begin
                if (scan == PH_ESC) begin
                    if (b == CH_LBR) begin
                        hold_byte(b);
                        scan = PH_PARAM;
                        done = 1'b1;
                    end else begin
                        release_held(fresh);
                    end
                end else if (scan == PH_PARAM) begin
                    if (is_param && held_cnt < HOLD_DEPTH) begin
                        hold_byte(b);
                        done = 1'b1;
                    end else if (!is_param && b == CH_M) begin
                        held_cnt = 0;
                        scan     = PH_IDLE;
                        done     = 1'b1;
                    end else begin
                        release_held(fresh);
                    end
                end else begin
                    scan = PH_IDLE;
                    if (b == CH_ESC) begin
                        held_cnt = 0;
                        hold_byte(b);
                        scan = PH_ESC;
                    end else begin
                        emit_kept(b, fresh);
                    end
                    done = 1'b1;
                end
            end
        endfunction

        // Note an accepted input byte and queue the results it must produce.
        function void take_byte(logic [7:0] b, logic is_last);
            text_result_t fresh [$];
            text_result_t r;
            strip_byte(b, fresh);
            if (is_last) begin
                release_held(fresh);
                if (fresh.size() == 0) begin
                    r.out_byte    = 8'h00;
                    r.byte_valid  = 1'b0;
                    r.end_of_run  = 1'b0;
                    r.visible_len = kept;
                    fresh.push_back(r);
                end
                fresh[fresh.size() - 1].end_of_run = 1'b1;
                scan     = PH_IDLE;
                held_cnt = 0;
                kept     = '0;
            end
            foreach (fresh[i])
                pending.push_back(fresh[i]);
        endfunction

        // Compare an accepted result with the oldest one still owed.
        function void check_result(text_result_t got);
            text_result_t want;
            if (pending.size() == 0) begin
                $error("unexpected result: out_byte %02h byte_valid %0b end_of_run %0b len %0d",
                       got.out_byte, got.byte_valid, got.end_of_run, got.visible_len);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.out_byte !== want.out_byte) begin
                $error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
                errors++;
            end
            if (got.byte_valid !== want.byte_valid) begin
                $error("byte_valid: expected %0b, got %0b", want.byte_valid, got.byte_valid);
                errors++;
            end
            if (got.end_of_run !== want.end_of_run) begin
                $error("end_of_run: expected %0b, got %0b", want.end_of_run, got.end_of_run);
                errors++;
            end
            if (got.visible_len !== want.visible_len) begin
                $error("visible_len: expected %0d, got %0d", want.visible_len, got.visible_len);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    sgr_in_if  in_ch ();
    sgr_out_if out_ch ();

    ansi_sgr_strip_unit uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .sgr_in  (in_ch),
        .sgr_out (out_ch)
    );

    sgr_strip_scoreboard scoreboard;
    logic [7:0]          text_q [$];
    int                  send_gap_pct;
    int                  recv_stall_pct;
    int                  quiet_cycles;

    // Idle percentages of sender and receiver for each phase.
    int GAP_PCT   [N_PHASES] = '{0, 55, 0, 38};
    int STALL_PCT [N_PHASES] = '{0, 0, 55, 38};

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Random text byte: mostly printable, sometimes anything at all.
    function automatic logic [7:0] plain_byte();
        if ($urandom_range(0, 1) == 0)
            return 8'($urandom_range(32, 126));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] param_byte();
        if ($urandom_range(0, 3) == 0)
            return CH_SEMI;
        return CH_DIG_0 + 8'($urandom_range(0, 9));
    endfunction

    // Build one random string: text runs, well-formed sequences and broken ones.
    function automatic void compose_string();
        int segs;
        int kind;
        int n;
        text_q.delete();
        segs = $urandom_range(1, 4);
        repeat (segs) begin
            kind = $urandom_range(0, 99);
            if (kind < 35) begin
                n = $urandom_range(1, 4);
                repeat (n) text_q.push_back(plain_byte());
            end else if (kind < 75) begin
                // Now and then long enough to fill or overflow the hold buffer.
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 16) : $urandom_range(0, 5);
                text_q.push_back(CH_ESC);
                text_q.push_back(CH_LBR);
                repeat (n) text_q.push_back(param_byte());
                text_q.push_back(CH_M);
            end else if (kind < 92) begin
                // A sequence cut short by an arbitrary byte, or by the end of the string.
                text_q.push_back(CH_ESC);
                if ($urandom_range(0, 3) != 0) begin
                    text_q.push_back(CH_LBR);
                    n = $urandom_range(0, 3);
                    repeat (n) text_q.push_back(param_byte());
                end
                if ($urandom_range(0, 3) != 0)
                    text_q.push_back(8'($urandom_range(0, 255)));
            end else begin
                case ($urandom_range(0, 3))
                    0:       text_q.push_back(CH_M);
                    1:       text_q.push_back(CH_LBR);
                    2:       text_q.push_back(CH_SEMI);
                    default: text_q.push_back(CH_ESC);
                endcase
            end
        end
    endfunction

    // Offer one byte, with random gaps before it, and wait for the transaction.
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        in_ch.last    <= is_last;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        scoreboard.take_byte(b, is_last);
    endtask

    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++)
            send_byte(text_q[i], i == text_q.size() - 1);
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (scoreboard.pending.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: check each result transaction, then stall at random.
    initial begin
        text_result_t got;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready) begin
                got.out_byte    = out_ch.out_byte;
                got.byte_valid  = out_ch.byte_valid;
                got.end_of_run  = out_ch.end_of_run;
                got.visible_len = out_ch.visible_len;
                scoreboard.check_result(got);
            end
            out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog: too many cycles without any transaction ends the run.
    initial begin
        quiet_cycles = 0;
        forever begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("ansi_sgr_strip_unit_tb: done, errors");
                $finish;
            end
        end
    end

    initial begin
        int sent;
        scoreboard     = new();
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        rst_n         <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.in_byte <= 8'h00;
        in_ch.last    <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < N_PHASES; ph++) begin
            send_gap_pct   = GAP_PCT[ph];
            recv_stall_pct = STALL_PCT[ph];

            if (ph == 0) begin
                // Hold overflow, a sequence broken by a non-ASCII byte, and a
                // complete sequence on the last byte, which leaves an end-only result.
                text_q.delete();
                text_q.push_back(CH_ESC);
                text_q.push_back(CH_LBR);
                repeat (14) text_q.push_back(CH_DIG_0 + 8'd5);
                text_q.push_back(CH_DIG_9);
                text_q.push_back(CH_ESC);
                text_q.push_back(CH_LBR);
                text_q.push_back(8'hFF);
                text_q.push_back(CH_ESC);
                text_q.push_back(CH_LBR);
                text_q.push_back(CH_M);
                send_text();
                // The end of the string flushes a pending ESC '['.
                text_q.delete();
                text_q.push_back(8'h00);
                text_q.push_back(CH_ESC);
                text_q.push_back(CH_LBR);
                send_text();
            end

            sent = 0;
            while (sent < RANDOM_PER_PHASE) begin
                compose_string();
                send_text();
                sent += text_q.size();
            end

            // The sender holds off until every owed result has arrived.
            in_ch.valid <= 1'b0;
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (scoreboard.pending.size() != 0) begin
            $error("results still owed at the end: %0d", scoreboard.pending.size());
            scoreboard.errors++;
        end
        if (scoreboard.errors == 0)
            $display("ansi_sgr_strip_unit_tb: done, clean");
        else
            $display("ansi_sgr_strip_unit_tb: done, errors");
        $finish;
    end

endmodule
